/* hw/rtl/alc_pkg.sv */
// ----------------------------------------------------------------------------
// alc_pkg
// Shared widths, constants, coefficient tables and helpers for the lux
// calculator datapath.
// ----------------------------------------------------------------------------
package alc_pkg;

  localparam int CNT_W    = 16;
  localparam int SCALE_W  = 19;
  localparam int PROD0_W  = CNT_W + SCALE_W;
  localparam int CH_W     = 25;
  localparam int REM_W    = 35;
  localparam int QUO_W    = 11;
  localparam int COEF_W   = 10;
  localparam int PROD_W   = CH_W + COEF_W;
  localparam int LUX_W    = 21;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;

  localparam int CH_SHIFT    = 10;
  localparam int RATIO_SHIFT = 9;
  localparam int LUX_SHIFT   = 14;

  localparam logic [SCALE_W-1:0] SCALE_13MS  = 19'h07517;
  localparam logic [SCALE_W-1:0] SCALE_101MS = 19'h00FE7;
  localparam logic               GAIN_1X     = 1'b0;

  localparam logic [1:0] MODE_13MS  = 2'd0;
  localparam logic [1:0] MODE_101MS = 2'd1;

  localparam logic [1:0] PKG_CS = 2'd0;
  localparam logic [1:0] PKG_T  = 2'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_HIGH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PACKAGE    = 2'd2;

  localparam logic [1:0]              MODE_RST = 2'd2;
  localparam logic                    GAIN_RST = 1'b0;
  localparam logic [1:0]              PKG_RST  = PKG_T;

  localparam logic [COEF_W-1:0] K1C = 10'h043;
  localparam logic [COEF_W-1:0] B1C = 10'h204;
  localparam logic [COEF_W-1:0] M1C = 10'h1ad;
  localparam logic [COEF_W-1:0] K1T = 10'h040;
  localparam logic [COEF_W-1:0] B1T = 10'h1f2;
  localparam logic [COEF_W-1:0] M1T = 10'h1be;

  typedef struct packed {
    logic [CH_W-1:0]  c0;
    logic [CH_W-1:0]  c1;
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } div_item_t;

  typedef struct packed {
    logic [COEF_W-1:0] b;
    logic [COEF_W-1:0] m;
  } coef_t;

  typedef struct packed {
    logic [COEF_W-1:0] k;
    logic [COEF_W-1:0] b;
    logic [COEF_W-1:0] m;
  } seg_t;

  localparam seg_t SEG_CS [8] = '{
    '{K1C,    B1C,    M1C},
    '{10'h085, 10'h228, 10'h2c1},
    '{10'h0c8, 10'h253, 10'h363},
    '{10'h10a, 10'h282, 10'h3df},
    '{10'h14d, 10'h177, 10'h1dd},
    '{10'h19a, 10'h101, 10'h127},
    '{10'h29a, 10'h037, 10'h02b},
    '{10'h29a, 10'h000, 10'h000}
  };

  localparam seg_t SEG_T [8] = '{
    '{K1T,    B1T,    M1T},
    '{10'h080, 10'h214, 10'h2d1},
    '{10'h0c0, 10'h23f, 10'h37b},
    '{10'h100, 10'h270, 10'h3fe},
    '{10'h138, 10'h16f, 10'h1fc},
    '{10'h19a, 10'h0d2, 10'h0fb},
    '{10'h29a, 10'h018, 10'h012},
    '{10'h29a, 10'h000, 10'h000}
  };

  function automatic logic [SCALE_W-1:0] chan_scale(input logic [1:0] mode,
                                                    input logic       gain);
    logic [SCALE_W-1:0] base;
    if (mode == MODE_13MS) begin
      base = SCALE_13MS;
    end else if (mode == MODE_101MS) begin
      base = SCALE_101MS;
    end else begin
      base = SCALE_W'(1) << CH_SHIFT;
    end
    if (gain == GAIN_1X) begin
      base = base << 4;
    end
    return base;
  endfunction

  // high: ratio is past every breakpoint, take the zero tail pair
  function automatic coef_t pick_coef(input logic [1:0]       pkg,
                                      input logic [QUO_W-1:0] ratio,
                                      input logic             high);
    coef_t c;
    seg_t  s;
    logic  hit;
    c   = '0;
    hit = 1'b0;
    for (int i = 0; i < 7; i++) begin
      s = (pkg == PKG_CS) ? SEG_CS[i] : SEG_T[i];
      if (!hit && !high && (ratio <= QUO_W'(s.k))) begin
        c.b = s.b;
        c.m = s.m;
        hit = 1'b1;
      end
    end
    if (pkg != PKG_CS && pkg != PKG_T) begin
      c = '0;
    end
    return c;
  endfunction

endpackage

/* hw/rtl/alc_div_cell.sv */
// ----------------------------------------------------------------------------
// alc_div_cell
// One restoring-division cell: resolves one quotient bit of the
// infrared/broadband ratio and passes the item to the next cell.
// ----------------------------------------------------------------------------
module alc_div_cell #(
  parameter int SHIFT = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  alc_pkg::div_item_t  up_item,
  output logic                dn_valid,
  input  logic                dn_ready,
  output alc_pkg::div_item_t  dn_item
);

  logic                          v_r, v_nxt;
  alc_pkg::div_item_t            item_r, item_nxt;
  logic [alc_pkg::REM_W-1:0]     dsh;
  logic                          ge;

  assign dsh      = alc_pkg::REM_W'(up_item.c0) << SHIFT;
  assign ge       = (up_item.rem >= dsh);
  assign up_ready = !v_r || dn_ready;

  always_comb begin
    item_nxt     = up_item;
    item_nxt.rem = ge ? (up_item.rem - dsh) : up_item.rem;
    item_nxt.quo = up_item.quo | (alc_pkg::QUO_W'(ge) << SHIFT);
    v_nxt        = up_ready ? up_valid : v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= item_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_item  = item_r;

endmodule

/* hw/rtl/alc_lux_stage.sv */
// ----------------------------------------------------------------------------
// alc_lux_stage
// Coefficient pick from the rounded ratio, offset/slope products, clamp,
// rounding and the output register.
// ----------------------------------------------------------------------------
module alc_lux_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [1:0]                  pkg,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  alc_pkg::div_item_t          up_item,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output logic [alc_pkg::LUX_W-1:0]   dn_lux
);

  localparam int TMP_W = alc_pkg::PROD_W + 1;

  logic                          l1_v_r, l2_v_r, l3_v_r;
  logic                          l1_rdy, l2_rdy, l3_rdy;
  logic [alc_pkg::CH_W-1:0]      c0_r, c1_r;
  alc_pkg::coef_t                coef_r;
  logic [alc_pkg::PROD_W-1:0]    pos_r, neg_r;
  logic [alc_pkg::LUX_W-1:0]     lux_r;

  logic                          c0_zero, high;
  logic [alc_pkg::QUO_W:0]       ratio_sum;
  logic [alc_pkg::QUO_W-1:0]     ratio;
  alc_pkg::coef_t                coef;
  logic [alc_pkg::PROD_W-1:0]    diff;
  logic [TMP_W-1:0]              tmp;

  assign l3_rdy   = !l3_v_r || dn_ready;
  assign l2_rdy   = !l2_v_r || l3_rdy;
  assign l1_rdy   = !l1_v_r || l2_rdy;
  assign up_ready = l1_rdy;

  // quotient fits 11 bits only while c1 < 2*c0
  assign c0_zero   = (up_item.c0 == '0);
  assign high      = !c0_zero && ({1'b0, up_item.c1} >= {up_item.c0, 1'b0});
  assign ratio_sum = c0_zero ? '0 : ({1'b0, up_item.quo} + 1'b1);
  assign ratio     = ratio_sum[alc_pkg::QUO_W:1];
  assign coef      = alc_pkg::pick_coef(pkg, ratio, high);

  assign diff = (pos_r > neg_r) ? (pos_r - neg_r) : '0;
  assign tmp  = TMP_W'(diff) + (TMP_W'(1) << (alc_pkg::LUX_SHIFT - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_v_r <= 1'b0;
      l2_v_r <= 1'b0;
      l3_v_r <= 1'b0;
    end else begin
      if (l1_rdy) begin
        l1_v_r <= up_valid;
      end
      if (l2_rdy) begin
        l2_v_r <= l1_v_r;
      end
      if (l3_rdy) begin
        l3_v_r <= l2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (l1_rdy && up_valid) begin
      c0_r   <= up_item.c0;
      c1_r   <= up_item.c1;
      coef_r <= coef;
    end
    if (l2_rdy && l1_v_r) begin
      pos_r <= alc_pkg::PROD_W'(c0_r) * alc_pkg::PROD_W'(coef_r.b);
      neg_r <= alc_pkg::PROD_W'(c1_r) * alc_pkg::PROD_W'(coef_r.m);
    end
    if (l3_rdy && l2_v_r) begin
      lux_r <= tmp[alc_pkg::LUX_SHIFT +: alc_pkg::LUX_W];
    end
  end

  assign dn_valid = l3_v_r;
  assign dn_lux   = lux_r;

endmodule

/* hw/rtl/ambient_light_lux_calculator.sv */
// ----------------------------------------------------------------------------
// ambient_light_lux_calculator
// Integer lux from a broadband/infrared count pair of an ambient light sensor.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per sample, tdata = {infrared_count, broadband}.
//   out_* : one transaction per sample, lux_value in tdata[20:0].
//   cfg_* : register writes (0 integration mode, 1 gain, 2 package); write
//           only while no sample is in flight. cfg_ready is always high.
//   Input to out_tvalid: the register after the channel scaling multipliers,
//   a chain of 11 division cells (one per quotient bit), and three registers
//   for coefficient pick, products and rounding.
//   One sample per cycle while out_tready is high; a stage holds one sample.
//   When out_tready is low the stages fill up behind the output register and
//   in_tready drops only once every stage is occupied; empty stages close up.
//   Reset empties the pipeline and loads integration mode 2, 1x gain and the
//   T/FN/CL package.
// ----------------------------------------------------------------------------
module ambient_light_lux_calculator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [31:0]                    in_tdata,   // broadband_count, infrared_count
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [23:0]                    out_tdata,  // lux_value, 3 zero bits
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [alc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [alc_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int NCELL = alc_pkg::QUO_W;

  logic [1:0]  mode_r, mode_nxt;
  logic        gain_r, gain_nxt;
  logic [1:0]  pkg_r, pkg_nxt;

  logic [alc_pkg::CNT_W-1:0]   ch0, ch1;
  logic [alc_pkg::SCALE_W-1:0] scale;
  logic [alc_pkg::PROD0_W-1:0] p0, p1;

  logic                s0_v_r;
  logic                s0_rdy;
  alc_pkg::div_item_t  s0_item_r;

  logic                cv   [NCELL+1];
  logic                crdy [NCELL+1];
  alc_pkg::div_item_t  citem [NCELL+1];

  logic [alc_pkg::LUX_W-1:0] lux;

  assign cfg_ready = 1'b1;

  always_comb begin
    mode_nxt = mode_r;
    gain_nxt = gain_r;
    pkg_nxt  = pkg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        alc_pkg::CFG_INTEG_MODE: mode_nxt = cfg_data;
        alc_pkg::CFG_GAIN_HIGH:  gain_nxt = cfg_data[0];
        alc_pkg::CFG_PACKAGE:    pkg_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= alc_pkg::MODE_RST;
      gain_r <= alc_pkg::GAIN_RST;
      pkg_r  <= alc_pkg::PKG_RST;
    end else begin
      mode_r <= mode_nxt;
      gain_r <= gain_nxt;
      pkg_r  <= pkg_nxt;
    end
  end

  assign ch0   = in_tdata[15:0];
  assign ch1   = in_tdata[31:16];
  assign scale = alc_pkg::chan_scale(mode_r, gain_r);
  assign p0    = alc_pkg::PROD0_W'(ch0) * alc_pkg::PROD0_W'(scale);
  assign p1    = alc_pkg::PROD0_W'(ch1) * alc_pkg::PROD0_W'(scale);

  assign s0_rdy    = !s0_v_r || crdy[0];
  assign in_tready = s0_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (s0_rdy) begin
      s0_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_rdy && in_tvalid) begin
      s0_item_r.c0  <= p0[alc_pkg::CH_SHIFT +: alc_pkg::CH_W];
      s0_item_r.c1  <= p1[alc_pkg::CH_SHIFT +: alc_pkg::CH_W];
      s0_item_r.rem <= {p1[alc_pkg::CH_SHIFT +: alc_pkg::CH_W],
                        (alc_pkg::RATIO_SHIFT + 1)'(0)};
      s0_item_r.quo <= '0;
    end
  end

  assign cv[0]    = s0_v_r;
  assign citem[0] = s0_item_r;

  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    alc_div_cell #(
      .SHIFT (NCELL - 1 - j)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (cv[j]),
      .up_ready (crdy[j]),
      .up_item  (citem[j]),
      .dn_valid (cv[j+1]),
      .dn_ready (crdy[j+1]),
      .dn_item  (citem[j+1])
    );
  end

  alc_lux_stage u_lux (
    .clk      (clk),
    .rst_n    (rst_n),
    .pkg      (pkg_r),
    .up_valid (cv[NCELL]),
    .up_ready (crdy[NCELL]),
    .up_item  (citem[NCELL]),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_lux   (lux)
  );

  assign out_tdata = {3'b000, lux};

endmodule

/* hw/rtl/alc_checker.sv */
// ----------------------------------------------------------------------------
// alc_checker
// Port-level checks for the lux calculator, bound to the top level.
// ----------------------------------------------------------------------------
module alc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out_tdata changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result presented right after reset");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty output stage");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready && (out_tdata[23:21] == 3'b000))
    else $error("config write refused or pad bits set");

endmodule

bind ambient_light_lux_calculator alc_checker u_alc_checker (.*);

/* bench/ambient_light_lux_calculator_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ambient_light_lux_calculator_test
// Checks the lux calculator against its own computation of integer lux.
// Count pairs stream in with random gaps, the result side stalls at random,
// and one long result-side hold fills the pipeline. The integration mode,
// gain and package are changed between phases, only while the block is idle.
// ----------------------------------------------------------------------------
module ambient_light_lux_calculator_test;

  localparam logic [alc_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [31:0]                    in_tdata   = '0;  // broadband_count, infrared_count
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [23:0]                    out_tdata;        // lux_value, 3 zero bits
  logic                           cfg_valid  = 1'b0;
  logic                           cfg_ready;
  logic [alc_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [alc_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

  ambient_light_lux_calculator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // local copy of the register file
  logic [1:0]  cfg_mode = alc_pkg::MODE_RST;
  logic        cfg_gain = alc_pkg::GAIN_RST;
  logic [1:0]  cfg_pkg  = alc_pkg::PKG_RST;

  logic [31:0] pending_pairs [$];
  logic [20:0] lux_expected [$];
  logic [20:0] lux_want;
  int          pairs_queued = 0;
  int          pairs_sent   = 0;
  int          mismatches   = 0;
  logic        in_taken     = 1'b0;
  logic        out_taken    = 1'b0;
  logic        rx_hold      = 1'b0;
  int          tx_wait      = 0;
  int          rx_wait      = 0;
  int          tx_gap_max   = 0;
  int          rx_gap_max   = 0;

  function automatic logic [20:0] predict_lux(input logic [15:0] bb, input logic [15:0] ir);
    logic [63:0] scale, c0, c1, q, ratio, pos, neg, diff;
    logic [9:0]  sk, sb, sm, b, m;
    logic        cs, found;
    int          i;
    if (cfg_mode == alc_pkg::MODE_13MS) begin
      scale = 64'h7517;
    end else if (cfg_mode == alc_pkg::MODE_101MS) begin
      scale = 64'h0FE7;
    end else begin
      scale = 64'd1024;
    end
    if (cfg_gain == alc_pkg::GAIN_1X) begin
      scale = scale << 4;
    end
    c0    = (64'(bb) * scale) >> 10;
    c1    = (64'(ir) * scale) >> 10;
    q     = (c0 == 64'd0) ? 64'd0 : (c1 << 10) / c0;
    ratio = (q + 64'd1) >> 1;
    cs    = (cfg_pkg == alc_pkg::PKG_CS);
    b     = '0;
    m     = '0;
    found = 1'b0;
    for (i = 0; i < 7; i++) begin
      case (i)
        0:       {sk, sb, sm} = cs ? {10'h043, 10'h204, 10'h1ad} : {10'h040, 10'h1f2, 10'h1be};
        1:       {sk, sb, sm} = cs ? {10'h085, 10'h228, 10'h2c1} : {10'h080, 10'h214, 10'h2d1};
        2:       {sk, sb, sm} = cs ? {10'h0c8, 10'h253, 10'h363} : {10'h0c0, 10'h23f, 10'h37b};
        3:       {sk, sb, sm} = cs ? {10'h10a, 10'h282, 10'h3df} : {10'h100, 10'h270, 10'h3fe};
        4:       {sk, sb, sm} = cs ? {10'h14d, 10'h177, 10'h1dd} : {10'h138, 10'h16f, 10'h1fc};
        5:       {sk, sb, sm} = cs ? {10'h19a, 10'h101, 10'h127} : {10'h19a, 10'h0d2, 10'h0fb};
        default: {sk, sb, sm} = cs ? {10'h29a, 10'h037, 10'h02b} : {10'h29a, 10'h018, 10'h012};
      endcase
      if (!found && ratio <= 64'(sk)) begin
        b     = sb;
        m     = sm;
        found = 1'b1;
      end
    end
    if (cfg_pkg != alc_pkg::PKG_CS && cfg_pkg != alc_pkg::PKG_T) begin
      b = '0;
      m = '0;
    end
    pos  = c0 * 64'(b);
    neg  = c1 * 64'(m);
    diff = (pos > neg) ? pos - neg : 64'd0;
    return 21'((diff + 64'd8192) >> 14);
  endfunction

  function automatic logic [31:0] random_pair();
    int bb, ir, kk;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        bb = $urandom_range(0, 65535);
        ir = $urandom_range(0, 65535);
      end
      3: begin
        bb = $urandom_range(0, 255);
        ir = $urandom_range(0, bb);
      end
      4, 5, 6: begin
        case ($urandom_range(0, 11))
          0:       kk = 'h043;
          1:       kk = 'h085;
          2:       kk = 'h0c8;
          3:       kk = 'h10a;
          4:       kk = 'h14d;
          5:       kk = 'h19a;
          6:       kk = 'h29a;
          7:       kk = 'h040;
          8:       kk = 'h080;
          9:       kk = 'h0c0;
          10:      kk = 'h100;
          default: kk = 'h138;
        endcase
        bb = $urandom_range(1, 50000);
        ir = (bb * kk) / 512 + $urandom_range(0, 6) - 3;
        if (ir < 0) ir = 0;
        if (ir > 65535) ir = 65535;
      end
      7: begin
        ir = $urandom_range(0, 65535);
        bb = $urandom_range(0, ir);
      end
      8: begin
        if ($urandom_range(0, 1) == 0) begin
          bb = 0;
          ir = $urandom_range(0, 65535);
        end else begin
          bb = $urandom_range(0, 65535);
          ir = 0;
        end
      end
      default: begin
        bb = $urandom_range(60000, 65535);
        ir = $urandom_range(0, 65535);
      end
    endcase
    return {16'(ir), 16'(bb)};
  endfunction

  task automatic push_pair(input logic [15:0] bb, input logic [15:0] ir);
    pending_pairs.push_back({ir, bb});
    pairs_queued++;
  endtask

  task automatic push_random(input int count);
    for (int n = 0; n < count; n++) begin
      pending_pairs.push_back(random_pair());
      pairs_queued++;
    end
  endtask

  // returns at a falling edge once every pair is in and every lux is out
  task automatic settle();
    @(negedge clk);
    while (pairs_sent != pairs_queued || lux_expected.size() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [alc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [alc_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_taken) begin
        if (in_taken) tx_wait = $urandom_range(0, tx_gap_max);
        if (tx_wait == 0 && pending_pairs.size() != 0) begin
          in_tdata  <= pending_pairs.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
          if (tx_wait != 0) tx_wait--;
        end
      end
    end
  end

  // result-side flow control
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) rx_wait = $urandom_range(0, rx_gap_max);
      if (rx_hold || rx_wait != 0) begin
        out_tready <= 1'b0;
        if (!rx_hold && rx_wait != 0) rx_wait--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // monitor: register writes, accepted pairs, returned lux
  always @(posedge clk) begin
    in_taken  <= rst_n && in_tvalid && in_tready;
    out_taken <= rst_n && out_tvalid && out_tready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          alc_pkg::CFG_INTEG_MODE: cfg_mode = cfg_data;
          alc_pkg::CFG_GAIN_HIGH:  cfg_gain = cfg_data[0];
          alc_pkg::CFG_PACKAGE:    cfg_pkg  = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        lux_expected.push_back(predict_lux(in_tdata[15:0], in_tdata[31:16]));
        pairs_sent++;
      end
      if (out_tvalid && out_tready) begin
        if (lux_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected lux transaction: %0d", out_tdata[20:0]);
        end else begin
          lux_want = lux_expected.pop_front();
          if (out_tdata !== {3'b000, lux_want}) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("lux mismatch: expected %0d pad 0, got %0d pad %0d",
                       lux_want, out_tdata[20:0], out_tdata[23:21]);
            end
          end
        end
      end
    end
  end

  initial begin
    logic [1:0] mode, gain_word, pkg;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: 402 ms, 1x gain, T package
    push_pair(16'd0, 16'd0);
    push_pair(16'd0, 16'd65535);
    push_pair(16'd65535, 16'd0);
    push_pair(16'd65535, 16'd65535);
    push_pair(16'd1, 16'd0);
    push_pair(16'd1, 16'd1);
    push_pair(16'd1000, 16'd125);
    push_pair(16'd1000, 16'd126);
    push_pair(16'd1000, 16'd250);
    push_pair(16'd1000, 16'd609);
    push_pair(16'd1000, 16'd801);
    push_pair(16'd1000, 16'd802);
    push_pair(16'd1000, 16'd1301);
    push_pair(16'd1000, 16'd1302);
    settle();
    tx_gap_max = 8;
    rx_gap_max = 8;
    push_random(30);

    // CS package, unit scale: clamp of a negative difference near the top
    settle();
    cfg_write(alc_pkg::CFG_PACKAGE, alc_pkg::PKG_CS);
    cfg_write(alc_pkg::CFG_GAIN_HIGH, 2'd1);
    cfg_write(CFG_SPARE, 2'd3);
    cfg_valid <= 1'b0;
    push_pair(16'd1000, 16'd1300);
    push_pair(16'd1000, 16'd1303);
    push_pair(16'd40000, 16'd20000);
    push_pair(16'd65535, 16'd65535);
    push_pair(16'd65535, 16'd1);

    for (int ph = 0; ph < 11; ph++) begin
      mode      = 2'(ph % 4);
      gain_word = 2'((ph / 3) % 4);
      pkg       = (ph == 5) ? 2'd3 : (ph == 9) ? 2'd2 : 2'(ph % 2);
      settle();
      cfg_write(alc_pkg::CFG_INTEG_MODE, mode);
      cfg_write(alc_pkg::CFG_GAIN_HIGH, gain_word);
      cfg_write(alc_pkg::CFG_PACKAGE, pkg);
      cfg_valid <= 1'b0;
      tx_gap_max = (ph % 3 == 1) ? 0 : 8;
      rx_gap_max = (ph % 4 == 2) ? 0 : 8;
      if (ph == 4) begin
        tx_gap_max = 0;
        fork
          begin
            @(posedge clk);
            rx_hold <= 1'b1;
            repeat (120) @(posedge clk);
            rx_hold <= 1'b0;
          end
        join_none
      end
      push_random(46);
    end

    settle();
    repeat (30) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/alc_pkg.sv
hw/rtl/alc_div_cell.sv
hw/rtl/alc_lux_stage.sv
hw/rtl/ambient_light_lux_calculator.sv
hw/rtl/alc_checker.sv
bench/ambient_light_lux_calculator_test.sv
